[src/tipd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipd_pkg
// Shared types, codes and tables of the tape image pulse decoder.
// ----------------------------------------------------------------------------
package tipd_pkg;

  localparam int unsigned NumSteps = 13;
  localparam int unsigned HeadMax  = 20;

  // parse phases
  localparam logic [2:0] PhSig  = 3'd0;
  localparam logic [2:0] PhType = 3'd1;
  localparam logic [2:0] PhHead = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhData = 3'd4;

  // result steps of one byte
  localparam logic [3:0] StepPilot  = 4'd0;
  localparam logic [3:0] StepSync1  = 4'd1;
  localparam logic [3:0] StepSync2  = 4'd2;
  localparam logic [3:0] StepBit0   = 4'd3;
  localparam logic [3:0] StepBit7   = 4'd10;
  localparam logic [3:0] StepPause  = 4'd11;
  localparam logic [3:0] StepStatus = 4'd12;

  // status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadHeader = 2'd1;
  localparam logic [1:0] StTruncated = 2'd2;
  localparam logic [1:0] StNoBlocks  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CfgPilotPulse = 3'd0;
  localparam logic [2:0] CfgSyncFirst  = 3'd1;
  localparam logic [2:0] CfgSyncSecond = 3'd2;
  localparam logic [2:0] CfgZeroPulse  = 3'd3;
  localparam logic [2:0] CfgOnePulse   = 3'd4;
  localparam logic [2:0] CfgPilotCount = 3'd5;
  localparam logic [2:0] CfgLastBits   = 3'd6;

  // block types
  localparam logic [7:0] BlkStd   = 8'h10;
  localparam logic [7:0] BlkTurbo = 8'h11;
  localparam logic [7:0] BlkPure  = 8'h14;

  localparam logic [15:0] AutoPilotHeader = 16'd8063;
  localparam logic [15:0] AutoPilotData   = 16'd3223;
  localparam logic [11:0] TStatesPerMs    = 12'd3500;

  typedef struct packed {
    logic        known;
    logic [4:0]  len;
  } head_len_t;

  typedef struct packed {
    logic [NumSteps-1:0] mask;
    logic [7:0]          data;
    logic [15:0]         pilot_len;
    logic [15:0]         sync1;
    logic [15:0]         sync2;
    logic [15:0]         zero;
    logic [15:0]         one;
    logic [15:0]         pilot_cnt;
    logic [15:0]         pause;
    logic [1:0]          status;
    logic                first;
  } job_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    sig_byte = 8'h5A;
      3'd1:    sig_byte = 8'h58;
      3'd2:    sig_byte = 8'h54;
      3'd3:    sig_byte = 8'h61;
      3'd4:    sig_byte = 8'h70;
      3'd5:    sig_byte = 8'h65;
      3'd6:    sig_byte = 8'h21;
      default: sig_byte = 8'h1A;
    endcase
  endfunction

  function automatic head_len_t head_len(input logic [7:0] t);
    head_len_t r;
    r.known = 1'b1;
    case (t)
      8'h10:               r.len = 5'd4;
      8'h11:               r.len = 5'd18;
      8'h12:               r.len = 5'd4;
      8'h13:               r.len = 5'd1;
      8'h14:               r.len = 5'd10;
      8'h15:               r.len = 5'd8;
      8'h18, 8'h19:        r.len = 5'd4;
      8'h20:               r.len = 5'd2;
      8'h21:               r.len = 5'd1;
      8'h22, 8'h25, 8'h27: r.len = 5'd0;
      8'h23, 8'h24:        r.len = 5'd2;
      8'h26:               r.len = 5'd2;
      8'h28:               r.len = 5'd2;
      8'h2A:               r.len = 5'd4;
      8'h2B:               r.len = 5'd5;
      8'h30:               r.len = 5'd1;
      8'h31:               r.len = 5'd2;
      8'h32:               r.len = 5'd2;
      8'h33:               r.len = 5'd1;
      8'h35:               r.len = 5'd20;
      8'h5A:               r.len = 5'd9;
      default: begin
        r.known = 1'b0;
        r.len   = 5'd0;
      end
    endcase
    return r;
  endfunction

endpackage

[src/tipd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tipd channel interfaces
// Byte channel into the decoder and run channel out of it.
// ----------------------------------------------------------------------------
interface tipd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       file_end;
  modport source (output valid, output file_byte, output file_end, input ready);
  modport sink   (input valid, input file_byte, input file_end, output ready);
endinterface

interface tipd_run_if;
  logic        valid;
  logic        ready;
  logic [27:0] pulse_length;
  logic [15:0] repeat_count;
  logic        block_start;
  logic        end_of_tape;
  logic [1:0]  tape_status;
  logic        run_last;
  modport source (output valid, output pulse_length, output repeat_count,
                  output block_start, output end_of_tape, output tape_status,
                  output run_last, input ready);
  modport sink   (input valid, input pulse_length, input repeat_count,
                  input block_start, input end_of_tape, input tape_status,
                  input run_last, output ready);
endinterface
`default_nettype wire

[src/tipd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tipd_parser
// Block parser: walks the image one byte a beat and builds the run job.
// ----------------------------------------------------------------------------
module tipd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tipd_byte_if.sink          byte_in,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          job_ready_i,
  output logic               job_valid_o,
  output tipd_pkg::job_t     job_o
);
  import tipd_pkg::*;

  logic [15:0] std_pilot_q, std_sync1_q, std_sync2_q, std_zero_q, std_one_q, std_cnt_q;
  logic [3:0]  std_bits_q;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [7:0]  kind_q, kind_d;
  logic [32:0] skip_q, skip_d;
  logic [23:0] drem_q, drem_d;
  logic [15:0] hf_q [6];
  logic [15:0] hf_d [6];
  logic [3:0]  used_q, used_d;
  logic [15:0] pause_q, pause_d;
  logic [7:0]  head_q [HeadMax];
  logic [7:0]  hbuf   [HeadMax];
  logic        pend_q, pend_d, seen_q, seen_d, stop_q, stop_d;
  logic [1:0]  err_q, err_d;

  logic        accept;
  logic [7:0]  b;
  head_len_t   hl_type, hl_kind;

  assign byte_in.ready = job_ready_i;
  assign accept        = byte_in.valid & job_ready_i;
  assign b             = byte_in.file_byte;
  assign hl_type       = head_len(b);
  assign hl_kind       = head_len(kind_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_pilot_q <= 16'd2168;
      std_sync1_q <= 16'd667;
      std_sync2_q <= 16'd735;
      std_zero_q  <= 16'd855;
      std_one_q   <= 16'd1710;
      std_cnt_q   <= 16'd0;
      std_bits_q  <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPilotPulse: std_pilot_q <= cfg_data_i;
        CfgSyncFirst:  std_sync1_q <= cfg_data_i;
        CfgSyncSecond: std_sync2_q <= cfg_data_i;
        CfgZeroPulse:  std_zero_q  <= cfg_data_i;
        CfgOnePulse:   std_one_q   <= cfg_data_i;
        CfgPilotCount: std_cnt_q   <= cfg_data_i;
        CfgLastBits:   std_bits_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // head buffer with the current byte merged in
  always_comb begin
    for (int i = 0; i < HeadMax; i++) hbuf[i] = head_q[i];
    if (phase_q == PhHead && fidx_q < 5'(HeadMax)) hbuf[fidx_q] = b;
  end

  always_comb begin
    logic [3:0]  used_raw;
    logic [15:0] pause_raw;
    logic [23:0] len_raw;
    logic        is_data;
    logic [32:0] body;
    logic        last;
    logic [3:0]  nbits;
    logic        pilot;
    logic [3:0]  nruns;
    logic [1:0]  st;

    phase_d = phase_q;
    fidx_d  = fidx_q;
    kind_d  = kind_q;
    skip_d  = skip_q;
    drem_d  = drem_q;
    for (int i = 0; i < 6; i++) hf_d[i] = hf_q[i];
    used_d  = used_q;
    pause_d = pause_q;
    pend_d  = pend_q;
    seen_d  = seen_q;
    stop_d  = stop_q;
    err_d   = err_q;

    used_raw  = 4'd0;
    pause_raw = 16'd0;
    len_raw   = 24'd0;
    is_data   = 1'b0;
    body      = 33'd0;
    last      = 1'b0;
    nbits     = 4'd0;
    pilot     = 1'b0;
    nruns     = 4'd0;
    st        = StOk;

    job_o           = '0;
    job_o.data      = b;
    job_o.pilot_len = hf_q[0];
    job_o.sync1     = hf_q[1];
    job_o.sync2     = hf_q[2];
    job_o.zero      = hf_q[3];
    job_o.one       = hf_q[4];
    job_o.pause     = pause_q;
    job_o.first     = pend_q;
    job_o.pilot_cnt = hf_q[5];
    if (hf_q[5] == 16'd0) job_o.pilot_cnt = b[7] ? AutoPilotData : AutoPilotHeader;

    if (!stop_q) begin
      case (phase_q)
        PhSig: begin
          if (fidx_q < 5'd8 && b != sig_byte(fidx_q[2:0])) begin
            stop_d = 1'b1;
            err_d  = StBadHeader;
          end else if (fidx_q >= 5'd9) begin
            fidx_d  = 5'd0;
            phase_d = PhType;
          end else begin
            fidx_d = fidx_q + 5'd1;
          end
        end
        PhType: begin
          kind_d = b;
          if (!hl_type.known) begin
            stop_d = 1'b1;
          end else if (hl_type.len != 5'd0) begin
            fidx_d  = 5'd0;
            phase_d = PhHead;
          end
        end
        PhHead: begin
          fidx_d = fidx_q + 5'd1;
          if (fidx_q + 5'd1 >= hl_kind.len) begin
            fidx_d = 5'd0;
            case (kind_q)
              BlkStd: begin
                hf_d[0] = std_pilot_q; hf_d[1] = std_sync1_q; hf_d[2] = std_sync2_q;
                hf_d[3] = std_zero_q;  hf_d[4] = std_one_q;   hf_d[5] = std_cnt_q;
                used_raw  = std_bits_q;
                pause_raw = {hbuf[1], hbuf[0]};
                len_raw   = {8'd0, hbuf[3], hbuf[2]};
                is_data   = 1'b1;
              end
              BlkTurbo: begin
                hf_d[0] = {hbuf[1], hbuf[0]}; hf_d[1] = {hbuf[3], hbuf[2]};
                hf_d[2] = {hbuf[5], hbuf[4]}; hf_d[3] = {hbuf[7], hbuf[6]};
                hf_d[4] = {hbuf[9], hbuf[8]}; hf_d[5] = {hbuf[11], hbuf[10]};
                used_raw  = (hbuf[12] > 8'd8) ? 4'd8 : hbuf[12][3:0];
                pause_raw = {hbuf[14], hbuf[13]};
                len_raw   = {hbuf[17], hbuf[16], hbuf[15]};
                is_data   = 1'b1;
              end
              BlkPure: begin
                hf_d[0] = 16'd0; hf_d[1] = 16'd0; hf_d[2] = 16'd0;
                hf_d[3] = {hbuf[1], hbuf[0]}; hf_d[4] = {hbuf[3], hbuf[2]};
                hf_d[5] = 16'd0;
                used_raw  = (hbuf[4] > 8'd8) ? 4'd8 : hbuf[4][3:0];
                pause_raw = {hbuf[6], hbuf[5]};
                len_raw   = {hbuf[9], hbuf[8], hbuf[7]};
                is_data   = 1'b1;
              end
              8'h13:        body = {24'd0, hbuf[0], 1'b0};
              8'h15:        body = {9'd0, hbuf[7], hbuf[6], hbuf[5]};
              8'h18, 8'h19: body = {1'b0, hbuf[3], hbuf[2], hbuf[1], hbuf[0]};
              8'h21, 8'h30: body = {25'd0, hbuf[0]};
              8'h26:        body = {16'd0, hbuf[1], hbuf[0], 1'b0};
              8'h28, 8'h32: body = {17'd0, hbuf[1], hbuf[0]};
              8'h31:        body = {25'd0, hbuf[1]};
              8'h33:        body = {25'd0, hbuf[0]} + {24'd0, hbuf[0], 1'b0};
              8'h35:        body = {1'b0, hbuf[19], hbuf[18], hbuf[17], hbuf[16]};
              default:      body = 33'd0;
            endcase
            if (is_data) begin
              used_d  = (used_raw > 4'd8) ? 4'd8 : used_raw;
              pause_d = pause_raw;
              seen_d  = 1'b1;
              if (len_raw == 24'd0) begin
                phase_d = PhType;
              end else begin
                drem_d  = len_raw;
                pend_d  = 1'b1;
                phase_d = PhData;
              end
            end else begin
              skip_d  = body;
              phase_d = (body != 33'd0) ? PhSkip : PhType;
            end
          end
        end
        PhSkip: begin
          if (skip_q != 33'd0) skip_d = skip_q - 33'd1;
          if (skip_q <= 33'd1) phase_d = PhType;
        end
        PhData: begin
          last  = (drem_q == 24'd1);
          nbits = last ? used_q : 4'd8;
          pilot = pend_q && (kind_q != BlkPure);
          job_o.mask[StepPilot] = pilot;
          job_o.mask[StepSync1] = pilot;
          job_o.mask[StepSync2] = pilot;
          for (int k = 0; k < 8; k++) job_o.mask[StepBit0 + 4'(k)] = (4'(k) < nbits);
          job_o.mask[StepPause] = last && (pause_q != 16'd0);
          nruns = nbits | {2'd0, pilot, pilot} | {3'd0, job_o.mask[StepPause]};
          if (nruns != 4'd0) pend_d = 1'b0;
          drem_d = drem_q - 24'd1;
          if (drem_q == 24'd1) phase_d = PhType;
        end
        default: phase_d = PhType;
      endcase
    end

    // status of the image on its last byte
    if (stop_d)                st = (err_d != StOk) ? err_d : (seen_d ? StOk : StNoBlocks);
    else if (phase_d == PhSig) st = StBadHeader;
    else if (phase_d != PhType) st = StTruncated;
    else                       st = seen_d ? StOk : StNoBlocks;
    job_o.status = st;
    job_o.mask[StepStatus] = byte_in.file_end;
  end

  assign job_valid_o = accept && (job_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      fidx_q  <= 5'd0;
      kind_q  <= 8'd0;
      skip_q  <= 33'd0;
      drem_q  <= 24'd0;
      for (int i = 0; i < 6; i++) hf_q[i] <= 16'd0;
      used_q  <= 4'd0;
      pause_q <= 16'd0;
      for (int i = 0; i < HeadMax; i++) head_q[i] <= 8'd0;
      pend_q  <= 1'b0;
      seen_q  <= 1'b0;
      stop_q  <= 1'b0;
      err_q   <= StOk;
    end else if (accept) begin
      if (byte_in.file_end) begin
        // new image starts with the next byte
        phase_q <= PhSig;
        fidx_q  <= 5'd0;
        kind_q  <= 8'd0;
        skip_q  <= 33'd0;
        drem_q  <= 24'd0;
        for (int i = 0; i < 6; i++) hf_q[i] <= 16'd0;
        used_q  <= 4'd0;
        pause_q <= 16'd0;
        for (int i = 0; i < HeadMax; i++) head_q[i] <= 8'd0;
        pend_q  <= 1'b0;
        seen_q  <= 1'b0;
        stop_q  <= 1'b0;
        err_q   <= StOk;
      end else begin
        phase_q <= phase_d;
        fidx_q  <= fidx_d;
        kind_q  <= kind_d;
        skip_q  <= skip_d;
        drem_q  <= drem_d;
        for (int i = 0; i < 6; i++) hf_q[i] <= hf_d[i];
        used_q  <= used_d;
        pause_q <= pause_d;
        for (int i = 0; i < HeadMax; i++) head_q[i] <= hbuf[i];
        pend_q  <= pend_d;
        seen_q  <= seen_d;
        stop_q  <= stop_d;
        err_q   <= err_d;
      end
    end
  end

endmodule
`default_nettype wire

[src/tipd_emitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tipd_emitter
// Holds a run job, sends its runs from a result reg, one per cycle while ready.
// ----------------------------------------------------------------------------
module tipd_emitter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire tipd_pkg::job_t job_i,
  output logic               job_ready_o,
  tipd_run_if.source         run_out
);
  import tipd_pkg::*;

  job_t                job_q;
  logic [NumSteps-1:0] mask_q, mask_d, sel;
  logic                first_q;
  logic                load_en;
  logic [3:0]          step;

  logic        valid_q;
  logic [27:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic        bs_q, eot_q, last_q;
  logic [1:0]  st_q;

  assign load_en     = (mask_q != '0) && (!valid_q || run_out.ready);
  assign sel         = mask_q & (~mask_q + NumSteps'(1));
  assign mask_d      = mask_q & ~sel;
  assign job_ready_o = (mask_q == '0) || (load_en && (mask_d == '0));

  always_comb begin
    step = 4'd0;
    for (int k = NumSteps - 1; k >= 0; k--) if (mask_q[k]) step = 4'(k);
  end

  always_comb begin
    len_d = 28'd0;
    cnt_d = 16'd1;
    case (step)
      StepPilot: begin
        len_d = {12'd0, job_q.pilot_len};
        cnt_d = job_q.pilot_cnt;
      end
      StepSync1: len_d = {12'd0, job_q.sync1};
      StepSync2: len_d = {12'd0, job_q.sync2};
      StepPause: len_d = {12'd0, job_q.pause} * {16'd0, TStatesPerMs};
      StepStatus: cnt_d = 16'd0;
      default: begin
        // data bit, msb first
        len_d = {12'd0, job_q.data[3'(StepBit7 - step)] ? job_q.one : job_q.zero};
        cnt_d = 16'd2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      first_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (load_en) begin
        valid_q <= 1'b1;
      end else if (run_out.ready) begin
        valid_q <= 1'b0;
      end
      if (job_valid_i) begin
        mask_q  <= job_i.mask;
        first_q <= job_i.first;
      end else if (load_en) begin
        mask_q <= mask_d;
        if (step != StepStatus) first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) job_q <= job_i;
    if (load_en) begin
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      bs_q   <= first_q && (step != StepStatus);
      eot_q  <= (step == StepStatus);
      st_q   <= (step == StepStatus) ? job_q.status : StOk;
      last_q <= (mask_d == '0);
    end
  end

  assign run_out.valid        = valid_q;
  assign run_out.pulse_length = len_q;
  assign run_out.repeat_count = cnt_q;
  assign run_out.block_start  = bs_q;
  assign run_out.end_of_tape  = eot_q;
  assign run_out.tape_status  = st_q;
  assign run_out.run_last     = last_q;

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && eot_q |-> last_q && len_q == 28'd0)
    else $error("status beat not last of its byte");
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |-> mask_q != '0)
    else $error("non-last beat with no runs left");
  a_start_not_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bs_q |-> !eot_q && cnt_q != 16'd0)
    else $error("block start on status beat");

endmodule
`default_nettype wire

[src/tape_image_pulse_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tape_image_pulse_decoder
// Decodes a tape image byte stream into pulse runs and an end-of-tape status.
// ----------------------------------------------------------------------------
// usage:
//   byte_in carries one image byte per beat, file_end on the last byte
//   run_out carries pulse runs (length in t-states, repeat count), then one
//   status beat after the last byte; run_last marks the final beat of a byte
//   runs are speculative: the receiver drops them if the status is not ok
//   a byte's first run goes from the run job register to the result register
//   throughput: a byte that makes runs holds the run job register until its
//   runs (up to 13) have gone out, one run per cycle from the result register
//   while the receiver is ready; the next byte is taken while the last run of
//   the job still waits
//   a stalled receiver freezes the result register and, through ready,
//   the byte channel; nothing is dropped
//   reset: registers at defaults, parser waits for the signature, no
//   beats pending
//   config writes (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle
// ----------------------------------------------------------------------------
module tape_image_pulse_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tipd_byte_if.sink        byte_in,
  tipd_run_if.source       run_out,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import tipd_pkg::*;

  // job handoff from parser to emitter
  logic job_valid;
  logic job_ready;
  job_t job;

  // block parser: state, timing snapshot, status
  tipd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in     (byte_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_ready_i (job_ready),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // run sequencer and result register
  tipd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .run_out     (run_out)
  );

endmodule
`default_nettype wire

[tb/tb_tape_image_pulse_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tape_image_pulse_decoder
// Feeds tape images beat by beat into the decoder and compares every run
// and status beat against a behavioral predictor of the parser.
// ----------------------------------------------------------------------------
module tb_tape_image_pulse_decoder;
  import tipd_pkg::*;

  typedef struct packed {
    logic [27:0] pulse_length;
    logic [15:0] repeat_count;
    logic        block_start;
    logic        end_of_tape;
    logic [1:0]  tape_status;
    logic        run_last;
  } run_beat_t;

  localparam int unsigned LimitCycles = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  tipd_byte_if byte_in ();
  tipd_run_if  run_out ();

  tape_image_pulse_decoder uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in   (byte_in.sink),
    .run_out   (run_out.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    byte_in.valid = 1'b0;
    byte_in.file_byte = '0;
    byte_in.file_end = 1'b0;
    run_out.ready = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: registers and parser copy
  // ---------------------------------------------------------------------
  logic [15:0] reg_pilot, reg_sync1, reg_sync2, reg_zero, reg_one, reg_pcnt;
  logic [3:0]  reg_bits;

  logic [2:0]  ph;
  int unsigned fidx;
  logic [7:0]  kind;
  longint unsigned skip_left;
  logic [23:0] data_left;
  logic [15:0] t_pilot, t_sync1, t_sync2, t_zero, t_one, t_pcnt, t_pause;
  logic [3:0]  t_bits;
  logic [7:0]  head_buf [HeadMax];
  logic        first_pend, seen_block, stopped;
  logic [1:0]  err;

  run_beat_t expected_runs [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  localparam logic [7:0] SigBytes [8] = '{8'h5A, 8'h58, 8'h54, 8'h61,
                                          8'h70, 8'h65, 8'h21, 8'h1A};

  task automatic parser_clear();
    ph = PhSig; fidx = 0; kind = '0; skip_left = 0; data_left = '0;
    {t_pilot, t_sync1, t_sync2, t_zero, t_one, t_pcnt, t_pause} = '0;
    t_bits = '0;
    for (int i = 0; i < HeadMax; i++) head_buf[i] = '0;
    first_pend = 1'b0; seen_block = 1'b0; stopped = 1'b0; err = StOk;
  endtask

  // header length per block type, -1 for unknown
  function automatic int hdr_len(logic [7:0] t);
    case (t)
      8'h10, 8'h12, 8'h18, 8'h19, 8'h2A: return 4;
      8'h11: return 18;
      8'h13, 8'h21, 8'h30, 8'h33: return 1;
      8'h14: return 10;
      8'h15: return 8;
      8'h20, 8'h23, 8'h24, 8'h26, 8'h28, 8'h31, 8'h32: return 2;
      8'h22, 8'h25, 8'h27: return 0;
      8'h2B: return 5;
      8'h35: return 20;
      8'h5A: return 9;
      default: return -1;
    endcase
  endfunction

  function automatic logic [31:0] hbyte(int i);
    return (i < HeadMax) ? 32'(head_buf[i]) : 32'd0;
  endfunction
  function automatic logic [31:0] hword(int i);
    return hbyte(i) | (hbyte(i + 1) << 8);
  endfunction
  function automatic logic [31:0] htri(int i);
    return hword(i) | (hbyte(i + 2) << 16);
  endfunction

  task automatic push_run(logic [27:0] len, logic [15:0] cnt);
    run_beat_t b;
    b = '0;
    b.pulse_length = len;
    b.repeat_count = cnt;
    b.block_start = first_pend;
    first_pend = 1'b0;
    expected_runs = {expected_runs, b};
  endtask

  task automatic open_data(logic [31:0] used, logic [15:0] pause, logic [23:0] len);
    t_bits = (used > 8) ? 4'd8 : used[3:0];
    t_pause = pause;
    seen_block = 1'b1;
    if (len == 0) begin
      ph = PhType;
    end else begin
      data_left = len;
      first_pend = 1'b1;
      ph = PhData;
    end
  endtask

  task automatic close_header();
    longint unsigned body;
    body = 0;
    case (kind)
      BlkStd: begin
        t_pilot = reg_pilot; t_sync1 = reg_sync1; t_sync2 = reg_sync2;
        t_zero = reg_zero; t_one = reg_one; t_pcnt = reg_pcnt;
        open_data(32'(reg_bits), 16'(hword(0)), 24'(hword(2)));
        return;
      end
      BlkTurbo: begin
        t_pilot = 16'(hword(0)); t_sync1 = 16'(hword(2)); t_sync2 = 16'(hword(4));
        t_zero = 16'(hword(6)); t_one = 16'(hword(8)); t_pcnt = 16'(hword(10));
        open_data(hbyte(12), 16'(hword(13)), 24'(htri(15)));
        return;
      end
      BlkPure: begin
        t_pilot = '0; t_sync1 = '0; t_sync2 = '0;
        t_zero = 16'(hword(0)); t_one = 16'(hword(2)); t_pcnt = '0;
        open_data(hbyte(4), 16'(hword(5)), 24'(htri(7)));
        return;
      end
      8'h13: body = 64'(hbyte(0)) * 64'd2;
      8'h15: body = 64'(htri(5));
      8'h18, 8'h19: body = 64'(htri(0)) | (64'(hbyte(3)) << 24);
      8'h21, 8'h30: body = 64'(hbyte(0));
      8'h26: body = 64'(hword(0)) * 64'd2;
      8'h28, 8'h32: body = 64'(hword(0));
      8'h31: body = 64'(hbyte(1));
      8'h33: body = 64'(hbyte(0)) * 64'd3;
      8'h35: body = 64'(htri(16)) | (64'(hbyte(19)) << 24);
      default: body = 0;
    endcase
    skip_left = body;
    ph = (body != 0) ? PhSkip : PhType;
  endtask

  task automatic decode_data(logic [7:0] b);
    logic last;
    int unsigned nbits;
    logic [15:0] cnt;
    last = (data_left == 24'd1);
    nbits = last ? 32'(t_bits) : 32'd8;
    if (first_pend && kind != BlkPure) begin
      cnt = t_pcnt;
      if (cnt == 0) cnt = (b < 128) ? AutoPilotHeader : AutoPilotData;
      push_run(28'(t_pilot), cnt);
      push_run(28'(t_sync1), 16'd1);
      push_run(28'(t_sync2), 16'd1);
    end
    for (int k = 0; k < nbits; k++)
      push_run(28'(b[7-k] ? t_one : t_zero), 16'd2);
    if (last && t_pause != 0) push_run(28'(32'(t_pause) * 3500), 16'd1);
    data_left = data_left - 24'd1;
    if (data_left == 0) ph = PhType;
  endtask

  // predicts all beats caused by one accepted byte
  task automatic predict_byte(logic [7:0] b, logic fend);
    int base;
    int h;
    run_beat_t s;
    base = expected_runs.size();
    if (!stopped) begin
      case (ph)
        PhSig: begin
          if (fidx < 8 && b != SigBytes[fidx]) begin
            stopped = 1'b1; err = StBadHeader;
          end else begin
            fidx++;
            if (fidx >= 10) begin fidx = 0; ph = PhType; end
          end
        end
        PhType: begin
          kind = b;
          h = hdr_len(b);
          if (h < 0) stopped = 1'b1;
          else if (h > 0) begin fidx = 0; ph = PhHead; end
        end
        PhHead: begin
          if (fidx < HeadMax) head_buf[fidx] = b;
          fidx++;
          if (fidx >= hdr_len(kind)) begin fidx = 0; close_header(); end
        end
        PhSkip: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) ph = PhType;
        end
        PhData: decode_data(b);
        default: ph = PhType;
      endcase
    end
    if (fend) begin
      s = '0;
      s.end_of_tape = 1'b1;
      if (stopped) s.tape_status = (err != StOk) ? err : (seen_block ? StOk : StNoBlocks);
      else if (ph == PhSig) s.tape_status = StBadHeader;
      else if (ph != PhType) s.tape_status = StTruncated;
      else s.tape_status = seen_block ? StOk : StNoBlocks;
      expected_runs = {expected_runs, s};
      parser_clear();
    end
    if (expected_runs.size() > base) expected_runs[$].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  logic idle_phase = 1'b0;

  // one beat on the byte channel; prediction at acceptance
  task automatic send_byte(logic [7:0] b, logic fend = 1'b0);
    int unsigned g;
    g = idle_phase ? 0 : pick_gap();
    if (g > 0) begin
      byte_in.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    byte_in.valid <= 1'b1;
    byte_in.file_byte <= b;
    byte_in.file_end <= fend;
    @(posedge clk_i);
    while (!byte_in.ready) @(posedge clk_i);
    predict_byte(b, fend);
  endtask

  task automatic release_bus();
    byte_in.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for the decoder to drain, then let it settle
  task automatic wait_drained();
    release_bus();
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPilotPulse: reg_pilot = val;
      CfgSyncFirst:  reg_sync1 = val;
      CfgSyncSecond: reg_sync2 = val;
      CfgZeroPulse:  reg_zero = val;
      CfgOnePulse:   reg_one = val;
      CfgPilotCount: reg_pcnt = val;
      CfgLastBits:   reg_bits = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_signature();
    for (int i = 0; i < 8; i++) send_byte(SigBytes[i]);
    send_byte(8'($urandom)); send_byte(8'($urandom));
  endtask

  task automatic send_word(logic [15:0] w);
    send_byte(w[7:0]); send_byte(w[15:8]);
  endtask

  // data body with random content; flag marks the last byte as the image end
  task automatic send_body(int unsigned n, logic fend_last);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), fend_last && (i == n - 1));
  endtask

  task automatic send_std(logic [15:0] pause, int unsigned n);
    send_byte(BlkStd); send_word(pause); send_word(16'(n));
    send_body(n, 1'b0);
  endtask

  task automatic send_turbo(logic [3:0] used, logic [15:0] pause, int unsigned n);
    send_byte(BlkTurbo);
    for (int i = 0; i < 6; i++) send_word(16'($urandom));
    send_byte(8'(used)); send_word(pause);
    send_word(16'(n)); send_byte(8'h00);
    send_body(n, 1'b0);
  endtask

  task automatic send_pure(logic [7:0] used, logic [15:0] pause, int unsigned n);
    send_byte(BlkPure);
    send_word(16'($urandom)); send_word(16'($urandom));
    send_byte(used); send_word(pause); send_word(16'(n)); send_byte(8'h00);
    send_body(n, 1'b0);
  endtask

  // a skipped block with a small body
  task automatic send_skipped();
    logic [7:0] t;
    int unsigned h;
    t = 8'h13;
    case ($urandom_range(0, 7))
      0: t = 8'h13; 1: t = 8'h21; 2: t = 8'h30; 3: t = 8'h32;
      4: t = 8'h22; 5: t = 8'h20; 6: t = 8'h2B; default: t = 8'h33;
    endcase
    send_byte(t);
    h = hdr_len(t);
    case (t)
      8'h13, 8'h21, 8'h30, 8'h33: send_byte(8'($urandom_range(0, 3)));
      8'h32: send_word(16'($urandom_range(0, 3)));
      default: for (int i = 0; i < h; i++) send_byte(8'($urandom));
    endcase
    if (t == 8'h13) for (int i = 0; i < 2 * head_buf[0]; i++) send_byte(8'($urandom));
    else if (t == 8'h33) for (int i = 0; i < 3 * head_buf[0]; i++) send_byte(8'($urandom));
    else if (t == 8'h21 || t == 8'h30 || t == 8'h32)
      for (int i = 0; i < head_buf[0]; i++) send_byte(8'($urandom));
  endtask

  task automatic end_image(logic [7:0] b = 8'h00);
    send_byte(b, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    run_beat_t got, exp_b;
    cycles <= cycles + 1;
    if (rst_ni && run_out.valid && run_out.ready) begin
      got.pulse_length = run_out.pulse_length;
      got.repeat_count = run_out.repeat_count;
      got.block_start  = run_out.block_start;
      got.end_of_tape  = run_out.end_of_tape;
      got.tape_status  = run_out.tape_status;
      got.run_last     = run_out.run_last;
      if (expected_runs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %h", got);
      end else begin
        exp_b = expected_runs.pop_front();
        if (got !== exp_b) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp len=%0d rep=%0d bs=%b eot=%b st=%0d last=%b",
                      " | got len=%0d rep=%0d bs=%b eot=%b st=%0d last=%b"},
                     exp_b.pulse_length, exp_b.repeat_count, exp_b.block_start,
                     exp_b.end_of_tape, exp_b.tape_status, exp_b.run_last,
                     got.pulse_length, got.repeat_count, got.block_start,
                     got.end_of_tape, got.tape_status, got.run_last);
        end
      end
    end
  end

  // ready toggles with mostly short stalls
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      g = idle_phase ? 0 : pick_gap();
      if (g > 0) begin
        run_out.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      run_out.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    wait (cycles >= LimitCycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_default_std();
    // standard blocks with auto pilot count, a pause on the last byte
    send_signature();
    send_byte(BlkStd); send_word(16'd1); send_word(16'd2);
    send_byte(8'h00); send_byte(8'hFF);
    send_std(16'hFFFF, 1);
    end_image();
    wait_drained();
  endtask

  task automatic test_extremes_cfg();
    // all registers at their extremes, clamping and zero used bits
    write_reg(CfgPilotPulse, 16'hFFFF); write_reg(CfgSyncFirst, 16'h0000);
    write_reg(CfgSyncSecond, 16'hFFFF); write_reg(CfgZeroPulse, 16'h0000);
    write_reg(CfgOnePulse, 16'hFFFF); write_reg(CfgPilotCount, 16'hFFFF);
    write_reg(CfgLastBits, 16'd15);
    send_signature();
    send_std(16'd0, 1);
    send_turbo(4'd0, 16'd0, 1);
    send_pure(8'hFF, 16'd5, 2);
    send_pure(8'd3, 16'd0, 0);
    end_image();
    wait_drained();
    write_reg(CfgLastBits, 16'd0); write_reg(CfgPilotCount, 16'd1);
    send_signature(); send_std(16'd2, 1); end_image(8'h7F);
    wait_drained();
  endtask

  task automatic test_status_cases();
    // bad signature, short image, truncated, no blocks, unknown type
    send_byte(8'h5A); send_byte(8'h00); send_byte(8'h58); end_image();
    send_byte(8'h5A); end_image(8'h58);
    send_signature(); send_byte(BlkStd); send_word(16'd0); end_image();
    send_signature(); send_skipped(); end_image(8'h22);
    send_signature(); send_pure(8'd8, 16'd0, 1); end_image(8'hFF);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_images();
    int unsigned sent;
    sent = 0;
    while (sent < 12) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
        write_reg(CfgPilotPulse, 16'($urandom)); write_reg(CfgSyncFirst, 16'($urandom));
        write_reg(CfgSyncSecond, 16'($urandom)); write_reg(CfgZeroPulse, 16'($urandom));
        write_reg(CfgOnePulse, 16'($urandom));
        write_reg(CfgPilotCount, ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom));
        write_reg(CfgLastBits, 16'($urandom_range(0, 15)));
      end
      idle_phase = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise image
        for (int i = 0; i < $urandom_range(0, 12); i++) send_byte(8'($urandom));
        end_image(8'($urandom));
      end else begin
        send_signature();
        for (int b = 0; b < $urandom_range(0, 3); b++)
          case ($urandom_range(0, 3))
            0: send_std(($urandom_range(0, 1)) ? 16'd0 : 16'($urandom), $urandom_range(0, 3));
            1: send_turbo(4'($urandom), 16'($urandom_range(0, 3)), $urandom_range(0, 3));
            2: send_pure(8'($urandom), 16'($urandom_range(0, 2)), $urandom_range(0, 3));
            default: send_skipped();
          endcase
        if ($urandom_range(0, 5) == 0) send_byte(8'($urandom)); // maybe unknown or partial
        end_image(8'($urandom));
      end
      sent++;
    end
    idle_phase = 1'b0;
    wait_drained();
  endtask

  initial begin
    reg_pilot = 16'd2168; reg_sync1 = 16'd667; reg_sync2 = 16'd735;
    reg_zero = 16'd855; reg_one = 16'd1710; reg_pcnt = 16'd0; reg_bits = 4'd8;
    parser_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_std();
    test_extremes_cfg();
    test_status_cases();
    test_random_images();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/tipd_pkg.sv
src/tipd_if.sv
src/tipd_parser.sv
src/tipd_emitter.sv
src/tape_image_pulse_decoder.sv
tb/tb_tape_image_pulse_decoder.sv
